@@ sv/sax_pkg.sv @@
// Shared types and constants for the stepper axis block.
// Used by the channel interfaces, the switch debouncer and the top level.
`default_nettype none

package sax_pkg;

   localparam int DEBOUNCE_SAMPLES = 5;
   localparam int SAMPLE_CNT_W     = 3;

   localparam logic [15:0] HALF_PERIOD_RESET  = 16'd25;
   localparam logic [15:0] STEPS_PER_MM_RESET = 16'd12800;
   localparam logic        HOMING_MODE_RESET  = 1'b0;
   localparam logic [7:0]  TRAVEL_MAX_RESET   = 8'd200;

   localparam logic [7:0]  POSITION_TOP = 8'd255;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_LOAD  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_HALF_PERIOD  = 2'd0,
      CSR_STEPS_PER_MM = 2'd1,
      CSR_HOMING_MODE  = 2'd2,
      CSR_TRAVEL_MAX   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic take;
      logic near_raw;
      logic far_raw;
   } sample_type;

   typedef struct packed {
      logic near_set;
      logic far_set;
      logic near_flag;
      logic far_flag;
   } dbn_status_type;

endpackage

`default_nettype wire

@@ sv/sax_if.sv @@
// Valid/ready channel interfaces for the stepper axis: request, response, register write.
// Depends on sax_pkg.
`default_nettype none

interface sax_req_if import sax_pkg::*; ();
   logic        valid;
   logic        ready;
   op_type      op;
   logic [7:0]  move_mm;
   logic        move_away;
   logic [7:0]  position_value;
   logic        sample_strobe;
   logic        near_switch_raw;
   logic        far_switch_raw;

   modport source (output valid, output op, output move_mm, output move_away,
                   output position_value, output sample_strobe,
                   output near_switch_raw, output far_switch_raw, input ready);
   modport sink   (input valid, input op, input move_mm, input move_away,
                   input position_value, input sample_strobe,
                   input near_switch_raw, input far_switch_raw, output ready);
endinterface

interface sax_rsp_if import sax_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        step_level;
   logic        dir_level;
   logic        busy_res;
   logic [7:0]  position_mm;
   logic        near_limit;
   logic        far_limit;
   logic        load_fault;

   modport source (output valid, output step_level, output dir_level, output busy_res,
                   output position_mm, output near_limit, output far_limit,
                   output load_fault, input ready);
   modport sink   (input valid, input step_level, input dir_level, input busy_res,
                   input position_mm, input near_limit, input far_limit,
                   input load_fault, output ready);
endinterface

interface sax_csr_if import sax_pkg::*; ();
   logic           valid;
   logic           ready;
   csr_index_type  index;
   logic [15:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/stepper_axis_with_limit_switches.sv @@
// Top level of one stepper axis: step/dir pulse generator, position tracking, limit switches.
// Depends on sax_pkg, sax_if and sax_debounce.
//
// Every request word is one tick, start, load or no-op, and returns exactly one response
// word in the cycle after it is accepted. The axis takes one word per clock: the state update is a
// single pass from the state registers to the response register, and the request side stays
// ready while a response is waiting as long as the sink takes that response in the same
// cycle. Register writes are always ready and take effect on the next word.
`default_nettype none

module stepper_axis_with_limit_switches import sax_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   sax_req_if.sink     req_if,
   sax_rsp_if.source   rsp_if,
   sax_csr_if.sink     csr_if
);

   logic [15:0] half_period_ff;
   logic [15:0] steps_per_mm_ff;
   logic        homing_mode_ff;
   logic [7:0]  travel_max_ff;

   logic [7:0]  position_ff, position_in;
   logic [7:0]  mm_left_ff, mm_left_in;
   logic [15:0] steps_in_mm_ff, steps_in_mm_in;
   logic [15:0] phase_timer_ff, phase_timer_in;
   logic        step_high_ff, step_high_in;
   logic        moving_ff, moving_in;
   logic        heading_away_ff, heading_away_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_step_ff;
   logic        rsp_dir_ff;
   logic        rsp_busy_ff;
   logic [7:0]  rsp_position_ff;
   logic        rsp_near_ff;
   logic        rsp_far_ff;
   logic        rsp_fault_ff;

   logic           accept;
   logic           is_tick;
   logic           fault;
   logic           stop_now;
   logic [15:0]    half_eff;
   logic [15:0]    spm_eff;
   logic [15:0]    timer_inc;
   logic [15:0]    steps_inc;
   logic [7:0]     mm_dec;
   sample_type     sample;
   dbn_status_type dbn_status;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_tick      = (req_if.op == OP_TICK);
   assign csr_if.ready = 1'b1;

   assign sample.take     = accept && is_tick && req_if.sample_strobe;
   assign sample.near_raw = req_if.near_switch_raw;
   assign sample.far_raw  = req_if.far_switch_raw;

   sax_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .sample (sample),
      .status (dbn_status)
   );

   always_comb begin
      half_eff  = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
      spm_eff   = (steps_per_mm_ff == 16'd0) ? 16'd1 : steps_per_mm_ff;
      timer_inc = phase_timer_ff + 16'd1;
      steps_inc = steps_in_mm_ff + 16'd1;
      mm_dec    = mm_left_ff - 8'd1;

      position_in     = position_ff;
      mm_left_in      = mm_left_ff;
      steps_in_mm_in  = steps_in_mm_ff;
      phase_timer_in  = phase_timer_ff;
      step_high_in    = step_high_ff;
      moving_in       = moving_ff;
      heading_away_in = heading_away_ff;
      fault           = 1'b0;
      stop_now        = 1'b0;

      if (accept) begin
         case (req_if.op)
            OP_TICK: begin
               if (moving_ff) begin
                  if (timer_inc < half_eff) begin
                     phase_timer_in = timer_inc;
                  end else begin
                     phase_timer_in = '0;
                     if (!step_high_ff) begin
                        step_high_in = 1'b1;
                     end else if (steps_inc >= spm_eff) begin
                        steps_in_mm_in = '0;
                        if (heading_away_ff && position_ff != POSITION_TOP) begin
                           position_in = position_ff + 8'd1;
                        end else if (!heading_away_ff && position_ff != 8'd0) begin
                           position_in = position_ff - 8'd1;
                        end
                        mm_left_in   = mm_dec;
                        step_high_in = 1'b0;
                        stop_now     = (mm_dec == 8'd0);
                     end else begin
                        steps_in_mm_in = steps_inc;
                        step_high_in   = 1'b0;
                     end
                  end
               end
               if (dbn_status.near_set) begin
                  position_in = 8'd0;
               end
               if (dbn_status.far_set) begin
                  position_in = travel_max_ff;
               end
               if ((dbn_status.near_set || dbn_status.far_set) && !homing_mode_ff) begin
                  stop_now = 1'b1;
               end
            end
            OP_START: begin
               heading_away_in = req_if.move_away;
               mm_left_in      = req_if.move_mm;
               steps_in_mm_in  = '0;
               phase_timer_in  = '0;
               moving_in       = (req_if.move_mm != 8'd0);
               step_high_in    = (req_if.move_mm == 8'd0);
            end
            OP_LOAD: begin
               position_in = req_if.position_value;
               fault       = (req_if.position_value > travel_max_ff);
            end
            default: begin
            end
         endcase
      end

      if (stop_now) begin
         moving_in      = 1'b0;
         mm_left_in     = '0;
         steps_in_mm_in = '0;
         phase_timer_in = '0;
         step_high_in   = 1'b1;
      end

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff  <= HALF_PERIOD_RESET;
         steps_per_mm_ff <= STEPS_PER_MM_RESET;
         homing_mode_ff  <= HOMING_MODE_RESET;
         travel_max_ff   <= TRAVEL_MAX_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_HALF_PERIOD:  half_period_ff  <= csr_if.data;
            CSR_STEPS_PER_MM: steps_per_mm_ff <= csr_if.data;
            CSR_HOMING_MODE:  homing_mode_ff  <= csr_if.data[0];
            CSR_TRAVEL_MAX:   travel_max_ff   <= csr_if.data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         mm_left_ff      <= '0;
         steps_in_mm_ff  <= '0;
         phase_timer_ff  <= '0;
         step_high_ff    <= 1'b1;
         moving_ff       <= 1'b0;
         heading_away_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         position_ff     <= position_in;
         mm_left_ff      <= mm_left_in;
         steps_in_mm_ff  <= steps_in_mm_in;
         phase_timer_ff  <= phase_timer_in;
         step_high_ff    <= step_high_in;
         moving_ff       <= moving_in;
         heading_away_ff <= heading_away_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_step_ff     <= step_high_in;
         rsp_dir_ff      <= heading_away_in;
         rsp_busy_ff     <= moving_in;
         rsp_position_ff <= position_in;
         rsp_near_ff     <= dbn_status.near_flag;
         rsp_far_ff      <= dbn_status.far_flag;
         rsp_fault_ff    <= fault;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.step_level  = rsp_step_ff;
   assign rsp_if.dir_level   = rsp_dir_ff;
   assign rsp_if.busy_res    = rsp_busy_ff;
   assign rsp_if.position_mm = rsp_position_ff;
   assign rsp_if.near_limit  = rsp_near_ff;
   assign rsp_if.far_limit   = rsp_far_ff;
   assign rsp_if.load_fault  = rsp_fault_ff;

endmodule

`default_nettype wire

@@ sv/sax_debounce.sv @@
// Limit switch debouncer: counts high samples of both switches over a window.
// Depends on sax_pkg.
`default_nettype none

module sax_debounce import sax_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire sample_type     sample,
   output dbn_status_type      status
);

   logic [SAMPLE_CNT_W-1:0] sample_index_ff, sample_index_in;
   logic [SAMPLE_CNT_W-1:0] near_hits_ff, near_hits_in;
   logic [SAMPLE_CNT_W-1:0] far_hits_ff, far_hits_in;
   logic                    near_flag_ff, near_flag_in;
   logic                    far_flag_ff, far_flag_in;
   logic [SAMPLE_CNT_W-1:0] index_next;
   logic [SAMPLE_CNT_W-1:0] near_next;
   logic [SAMPLE_CNT_W-1:0] far_next;
   logic                    judge;

   always_comb begin
      index_next = sample_index_ff + SAMPLE_CNT_W'(1);
      near_next  = near_hits_ff + SAMPLE_CNT_W'(sample.near_raw);
      far_next   = far_hits_ff + SAMPLE_CNT_W'(sample.far_raw);
      judge      = sample.take && (index_next >= SAMPLE_CNT_W'(DEBOUNCE_SAMPLES));

      sample_index_in = sample_index_ff;
      near_hits_in    = near_hits_ff;
      far_hits_in     = far_hits_ff;
      near_flag_in    = near_flag_ff;
      far_flag_in     = far_flag_ff;

      if (judge) begin
         sample_index_in = '0;
         near_hits_in    = '0;
         far_hits_in     = '0;
         near_flag_in    = (near_next == SAMPLE_CNT_W'(DEBOUNCE_SAMPLES));
         far_flag_in     = (far_next == SAMPLE_CNT_W'(DEBOUNCE_SAMPLES));
      end else if (sample.take) begin
         sample_index_in = index_next;
         near_hits_in    = near_next;
         far_hits_in     = far_next;
      end

      status.near_set  = judge && near_flag_in;
      status.far_set   = judge && far_flag_in;
      status.near_flag = near_flag_in;
      status.far_flag  = far_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         near_hits_ff    <= '0;
         far_hits_ff     <= '0;
         near_flag_ff    <= 1'b0;
         far_flag_ff     <= 1'b0;
      end else begin
         sample_index_ff <= sample_index_in;
         near_hits_ff    <= near_hits_in;
         far_hits_ff     <= far_hits_in;
         near_flag_ff    <= near_flag_in;
         far_flag_ff     <= far_flag_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/sax_checker.sv @@
// Port-level checks for the stepper axis top level, attached by bind.
// Depends on sax_pkg and stepper_axis_with_limit_switches.
`default_nettype none

module sax_checker import sax_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire op_type      req_op,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_step_level,
   input  wire logic        rsp_dir_level,
   input  wire logic        rsp_busy_res,
   input  wire logic [7:0]  rsp_position_mm,
   input  wire logic        rsp_load_fault
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word gave no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_level)
         && $stable(rsp_dir_level) && $stable(rsp_busy_res) && $stable(rsp_position_mm))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_step_level)
      else $error("step low on an idle axis");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op != OP_LOAD |=> !rsp_load_fault)
      else $error("load fault outside a load");

endmodule

bind stepper_axis_with_limit_switches sax_checker u_sax_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_op          (req_if.op),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_step_level  (rsp_if.step_level),
   .rsp_dir_level   (rsp_if.dir_level),
   .rsp_busy_res    (rsp_if.busy_res),
   .rsp_position_mm (rsp_if.position_mm),
   .rsp_load_fault  (rsp_if.load_fault)
);

`default_nettype wire

@@ bench/tb_stepper_axis_with_limit_switches.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the stepper axis: a directed table, then random phases over many
// register settings, each response checked against an in-bench model or a pinned table row.
// Depends on sax_pkg, the sax_if channel interfaces and the stepper_axis_with_limit_switches RTL.

module tb_stepper_axis_with_limit_switches;
   import sax_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_WORDS = 200;
   localparam int PHASES       = 10;

   typedef struct packed {
      op_type      op;
      logic [7:0]  move_mm;
      logic        move_away;
      logic [7:0]  position_value;
      logic        sample_strobe;
      logic        near_switch_raw;
      logic        far_switch_raw;
   } axis_word_type;

   typedef struct packed {
      logic        step_level;
      logic        dir_level;
      logic        busy_res;
      logic [7:0]  position_mm;
      logic        near_limit;
      logic        far_limit;
      logic        load_fault;
   } axis_status_type;

   typedef struct packed {
      logic             pinned;
      axis_status_type  status;
   } pin_type;

   typedef struct {
      logic           is_reg;
      csr_index_type  reg_index;
      logic [15:0]    reg_data;
      axis_word_type  word;
      pin_type        pin;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   sax_req_if req_bus ();
   sax_rsp_if rsp_bus ();
   sax_csr_if csr_bus ();

   stepper_axis_with_limit_switches u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // axis model state and registers
   logic [15:0] cfg_half;
   logic [15:0] cfg_spm;
   logic        cfg_homing;
   logic [7:0]  cfg_travel;

   logic [7:0]  pos_mm;
   logic [7:0]  mm_remaining;
   logic [15:0] step_count;
   logic [15:0] phase_ticks;
   logic        step_high;
   logic        in_motion;
   logic        going_away;
   logic [2:0]  sample_count;
   logic [2:0]  near_count;
   logic [2:0]  far_count;
   logic        near_on;
   logic        far_on;

   axis_status_type expected_q[$];
   pin_type         pin_q[$];
   plan_row_type    plan[$];

   int   errors = 0;
   int   idle_cycles = 0;
   bit   steady = 1'b0;
   logic near_pressed = 1'b0;
   logic far_pressed = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void halt_motion();
      in_motion    = 1'b0;
      mm_remaining = '0;
      step_count   = '0;
      phase_ticks  = '0;
      step_high    = 1'b1;
   endfunction

   function automatic void step_pulse();
      logic [15:0] half;
      logic [15:0] spm;
      half = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
      spm  = (cfg_spm == 16'd0) ? 16'd1 : cfg_spm;
      if (!in_motion) return;
      phase_ticks = phase_ticks + 16'd1;
      if (phase_ticks < half) return;
      phase_ticks = '0;
      if (!step_high) begin
         step_high = 1'b1;
         return;
      end
      step_count = step_count + 16'd1;
      if (step_count >= spm) begin
         step_count = '0;
         if (going_away) begin
            if (pos_mm != POSITION_TOP) pos_mm = pos_mm + 8'd1;
         end else if (pos_mm != 8'd0) begin
            pos_mm = pos_mm - 8'd1;
         end
         mm_remaining = mm_remaining - 8'd1;
         if (mm_remaining == 8'd0) begin
            halt_motion();
            return;
         end
      end
      step_high = 1'b0;
   endfunction

   function automatic void take_sample(logic near_raw, logic far_raw);
      near_count   = near_count + {2'b00, near_raw};
      far_count    = far_count + {2'b00, far_raw};
      sample_count = sample_count + 3'd1;
      if (sample_count < DEBOUNCE_SAMPLES) return;
      near_on = (near_count == DEBOUNCE_SAMPLES);
      far_on  = (far_count == DEBOUNCE_SAMPLES);
      if (near_on) begin
         pos_mm = 8'd0;
         if (!cfg_homing) halt_motion();
      end
      if (far_on) begin
         pos_mm = cfg_travel;
         if (!cfg_homing) halt_motion();
      end
      sample_count = '0;
      near_count   = '0;
      far_count    = '0;
   endfunction

   function automatic axis_status_type advance_axis(axis_word_type w);
      logic fault;
      fault = 1'b0;
      case (w.op)
         OP_TICK: begin
            step_pulse();
            if (w.sample_strobe) take_sample(w.near_switch_raw, w.far_switch_raw);
         end
         OP_START: begin
            going_away = w.move_away;
            halt_motion();
            if (w.move_mm != 8'd0) begin
               mm_remaining = w.move_mm;
               in_motion    = 1'b1;
               step_high    = 1'b0;
            end
         end
         OP_LOAD: begin
            pos_mm = w.position_value;
            fault  = (w.position_value > cfg_travel);
         end
         default: ;
      endcase
      return {step_high, going_away, in_motion, pos_mm, near_on, far_on, fault};
   endfunction

   function automatic void apply_register(csr_index_type idx, logic [15:0] value);
      case (idx)
         CSR_HALF_PERIOD:  cfg_half   = value;
         CSR_STEPS_PER_MM: cfg_spm    = value;
         CSR_HOMING_MODE:  cfg_homing = value[0];
         CSR_TRAVEL_MAX:   cfg_travel = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   function automatic void add_word(op_type op, logic [7:0] mm, logic away, logic [7:0] value,
                                    logic strobe, logic near, logic far);
      plan_row_type row;
      row.is_reg    = 1'b0;
      row.reg_index = CSR_HALF_PERIOD;
      row.reg_data  = '0;
      row.word      = {op, mm, away, value, strobe, near, far};
      row.pin       = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [15:0] value);
      plan_row_type row;
      row.is_reg    = 1'b1;
      row.reg_index = idx;
      row.reg_data  = value;
      row.word      = '0;
      row.pin       = '0;
      plan.push_back(row);
   endfunction

   function automatic void pin_last(logic step, logic dir, logic busy, logic [7:0] pos,
                                    logic near, logic far, logic fault);
      plan[$].pin = {1'b1, step, dir, busy, pos, near, far, fault};
   endfunction

   function automatic axis_word_type random_word();
      axis_word_type w;
      int pick;
      int start_odds;
      w.op              = OP_TICK;
      w.move_mm         = 8'($urandom);
      w.move_away       = 1'($urandom);
      w.position_value  = 8'($urandom);
      w.sample_strobe   = 1'($urandom);
      // hold each switch pressed or released for a stretch, with rare glitches
      if (near_pressed ? ($urandom_range(29) == 0) : ($urandom_range(79) == 0))
         near_pressed = !near_pressed;
      if (far_pressed ? ($urandom_range(29) == 0) : ($urandom_range(79) == 0))
         far_pressed = !far_pressed;
      w.near_switch_raw = near_pressed ^ ($urandom_range(24) == 0);
      w.far_switch_raw  = far_pressed ^ ($urandom_range(24) == 0);
      start_odds = in_motion ? 2 : 20;
      pick = $urandom_range(99);
      if (pick < start_odds) begin
         w.op = OP_START;
         if ($urandom_range(9) != 0) w.move_mm = 8'($urandom_range(1, 4));
      end else if (pick < start_odds + 5) begin
         w.op = OP_LOAD;
      end else if (pick < start_odds + 8) begin
         w.op = OP_NOP;
      end
      return w;
   endfunction

   task automatic send_word(input axis_word_type w, input pin_type pin);
      while (!steady && $urandom_range(99) < 38) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      pin_q.push_back(pin);
      req_bus.valid           <= 1'b1;
      req_bus.op              <= w.op;
      req_bus.move_mm         <= w.move_mm;
      req_bus.move_away       <= w.move_away;
      req_bus.position_value  <= w.position_value;
      req_bus.sample_strobe   <= w.sample_strobe;
      req_bus.near_switch_raw <= w.near_switch_raw;
      req_bus.far_switch_raw  <= w.far_switch_raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_axis();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 38);
   end

   always @(posedge clock) begin : monitor
      axis_word_type   w;
      axis_status_type want;
      axis_status_type got;
      pin_type         pin;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.step_level, rsp_bus.dir_level, rsp_bus.busy_res,
                   rsp_bus.position_mm, rsp_bus.near_limit, rsp_bus.far_limit,
                   rsp_bus.load_fault};
            if (expected_q.size() == 0) begin
               $display("%0t response word with nothing expected: %h", $time, got);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("step_level", 8'(want.step_level), 8'(got.step_level));
               check_field("dir_level", 8'(want.dir_level), 8'(got.dir_level));
               check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
               check_field("position_mm", want.position_mm, got.position_mm);
               check_field("near_limit", 8'(want.near_limit), 8'(got.near_limit));
               check_field("far_limit", 8'(want.far_limit), 8'(got.far_limit));
               check_field("load_fault", 8'(want.load_fault), 8'(got.load_fault));
            end
         end
         if (csr_bus.valid && csr_bus.ready) apply_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            w = {req_bus.op, req_bus.move_mm, req_bus.move_away, req_bus.position_value,
                 req_bus.sample_strobe, req_bus.near_switch_raw, req_bus.far_switch_raw};
            want = advance_axis(w);
            pin = pin_q.pop_front();
            if (pin.pinned) want = pin.status;
            expected_q.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int          ph;
      int          n;
      logic [15:0] half_cfg;
      logic [15:0] spm_cfg;
      logic        homing_cfg;
      logic [7:0]  travel_cfg;

      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.op              <= OP_TICK;
      req_bus.move_mm         <= '0;
      req_bus.move_away       <= 1'b0;
      req_bus.position_value  <= '0;
      req_bus.sample_strobe   <= 1'b0;
      req_bus.near_switch_raw <= 1'b0;
      req_bus.far_switch_raw  <= 1'b0;
      csr_bus.valid           <= 1'b0;
      csr_bus.index           <= CSR_HALF_PERIOD;
      csr_bus.data            <= '0;

      cfg_half     = HALF_PERIOD_RESET;
      cfg_spm      = STEPS_PER_MM_RESET;
      cfg_homing   = HOMING_MODE_RESET;
      cfg_travel   = TRAVEL_MAX_RESET;
      pos_mm       = '0;
      mm_remaining = '0;
      step_count   = '0;
      phase_ticks  = '0;
      step_high    = 1'b1;
      in_motion    = 1'b0;
      going_away   = 1'b1;
      sample_count = '0;
      near_count   = '0;
      far_count    = '0;
      near_on      = 1'b0;
      far_on       = 1'b0;

      // reset values, load bounds, empty and replaced moves
      add_word(OP_NOP, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd255, 1'b0, 1'b0, 1'b1);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd200, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd200, 1'b0, 1'b0, 1'b0);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd201, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd201, 1'b0, 1'b0, 1'b1);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_START, 8'd255, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
      pin_last(1'b0, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd77, 1'b0, 1'b0, 1'b0);
      add_word(OP_START, 8'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      // both switches in one window: far sets the position last, move aborts
      repeat (5) add_word(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1);
      pin_last(1'b1, 1'b0, 1'b0, 8'd200, 1'b1, 1'b1, 1'b0);
      // zero period and zero steps per mm act as one; saturate at the top
      add_reg(CSR_HALF_PERIOD, 16'd0);
      add_reg(CSR_STEPS_PER_MM, 16'd0);
      add_reg(CSR_TRAVEL_MAX, 16'd255);
      add_word(OP_LOAD, 8'd0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b0, 1'b0, 8'd255, 1'b1, 1'b1, 1'b0);
      add_word(OP_START, 8'd1, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      add_word(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      pin_last(1'b1, 1'b1, 1'b0, 8'd255, 1'b1, 1'b1, 1'b0);
      // homing: far switch forces the position, the move keeps going
      add_reg(CSR_HOMING_MODE, 16'd1);
      add_word(OP_START, 8'd3, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      repeat (5) add_word(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            drain_axis();
            write_register(plan[i].reg_index, plan[i].reg_data);
         end else begin
            send_word(plan[i].word, plan[i].pin);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         drain_axis();
         case (ph)
            0: begin
               half_cfg = 16'd1; spm_cfg = 16'd1; homing_cfg = 1'b0; travel_cfg = 8'd255;
            end
            2: begin
               half_cfg = 16'hFFFF; spm_cfg = 16'hFFFF; homing_cfg = 1'b1; travel_cfg = 8'd1;
            end
            3: begin
               half_cfg = 16'd1; spm_cfg = 16'd1; homing_cfg = 1'b1; travel_cfg = 8'd1;
            end
            default: begin
               half_cfg   = 16'($urandom_range(1, 3));
               spm_cfg    = 16'($urandom_range(1, 4));
               homing_cfg = 1'($urandom);
               travel_cfg = 8'($urandom_range(1, 255));
            end
         endcase
         write_register(CSR_HALF_PERIOD, half_cfg);
         write_register(CSR_STEPS_PER_MM, spm_cfg);
         write_register(CSR_HOMING_MODE, {15'($urandom), homing_cfg});
         write_register(CSR_TRAVEL_MAX, {8'($urandom), travel_cfg});
         steady = (ph == 5);
         for (n = 0; n < RANDOM_WORDS; n++) send_word(random_word(), '0);
      end

      steady = 1'b0;
      drain_axis();
      repeat (4) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
